@@ rtl/shb_pkg.sv @@
`default_nettype none

package shb_pkg;

    localparam int WORD_W = 32;
    localparam logic [7:0] PAD_FIRST_BYTE = 8'h80;
    localparam logic [5:0] LEN_FILL = 6'd56;
    localparam logic [5:0] LAST_FILL = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_INDEX = 3'd7;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_DRAIN,
        ST_OUT
    } shb_state_t;

    // sequencer to compression engine
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       init;
    } shb_ctl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int amt);
        rotr = (x >> amt) | (x << (WORD_W - amt));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

@@ rtl/sha256_byte_stream_hasher_top.sv @@
`default_nettype none

// SHA-256 over a byte stream. Each input request carries one byte (tdata), a
// byte-valid flag (tuser) and an end-of-message flag (tlast). A byte that does
// not complete a 64-byte block is just stored; the byte that completes a
// block starts one compression in the shared round unit, which runs one round
// per cycle and then adds into the hash, and the input is held off meanwhile.
// On tlast the block appends 0x80, zero bytes up to offset 56 of a block and
// the 64-bit bit length, one byte per cycle while the round unit is not busy,
// with one or two compressions in between, then returns the digest as eight
// result requests, word 0 first, tuser giving the word index and tlast marking
// word 7. No new input is taken until the last word has been taken; the next
// message then starts from the initial hash.
module sha256_byte_stream_hasher_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] byte_valid
    input  wire logic        s_axis_tlast,   // final_req
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);

    shb_pkg::shb_state_t state_reg, state_next;
    shb_pkg::shb_ctl_t   ctl;

    logic [63:0] count_reg, count_next;
    logic [2:0]  len_idx_reg, len_idx_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic [63:0] len_bits;
    logic [63:0] len_shifted;
    logic [5:0]  fill;
    logic        busy;
    logic [31:0] rd_word;

    shb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .rd_idx  (out_idx_reg),
        .rd_word (rd_word),
        .fill    (fill),
        .busy    (busy)
    );

    // message length in bits, wraps modulo 2^64; sent most significant byte first
    assign len_bits    = {count_reg[60:0], 3'b000};
    assign len_shifted = len_bits >> {~len_idx_reg, 3'b000};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= shb_pkg::ST_IDLE;
            count_reg   <= '0;
            len_idx_reg <= '0;
            out_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            len_idx_reg <= len_idx_next;
            out_idx_reg <= out_idx_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        len_idx_next  = len_idx_reg;
        out_idx_next  = out_idx_reg;
        ctl.push      = 1'b0;
        ctl.push_byte = s_axis_tdata;
        ctl.init      = 1'b0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        unique case (state_reg)
            shb_pkg::ST_IDLE: begin
                s_axis_tready = !busy;
                if (s_axis_tvalid && !busy) begin
                    if (s_axis_tuser) begin
                        ctl.push   = 1'b1;
                        count_next = count_reg + 64'd1;
                    end
                    if (s_axis_tlast) begin
                        state_next = shb_pkg::ST_PAD80;
                    end
                end
            end
            shb_pkg::ST_PAD80: begin
                if (!busy) begin
                    ctl.push      = 1'b1;
                    ctl.push_byte = shb_pkg::PAD_FIRST_BYTE;
                    state_next    = shb_pkg::ST_PADZ;
                end
            end
            shb_pkg::ST_PADZ: begin
                if (!busy) begin
                    if (fill == shb_pkg::LEN_FILL) begin
                        len_idx_next = '0;
                        state_next   = shb_pkg::ST_PADLEN;
                    end else begin
                        ctl.push      = 1'b1;
                        ctl.push_byte = 8'h00;
                    end
                end
            end
            shb_pkg::ST_PADLEN: begin
                ctl.push      = 1'b1;
                ctl.push_byte = len_shifted[7:0];
                len_idx_next  = len_idx_reg + 3'd1;
                if (len_idx_reg == shb_pkg::LAST_INDEX) begin
                    state_next = shb_pkg::ST_DRAIN;
                end
            end
            shb_pkg::ST_DRAIN: begin
                // wait for the closing compression
                if (!busy) begin
                    out_idx_next = '0;
                    state_next   = shb_pkg::ST_OUT;
                end
            end
            shb_pkg::ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == shb_pkg::LAST_INDEX) begin
                        ctl.init   = 1'b1;
                        count_next = '0;
                        state_next = shb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = shb_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tdata = rd_word;
    assign m_axis_tuser = out_idx_reg;
    assign m_axis_tlast = (out_idx_reg == shb_pkg::LAST_INDEX);

endmodule

`default_nettype wire

@@ rtl/shb_core.sv @@
`default_nettype none

module shb_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire shb_pkg::shb_ctl_t ctl,
    input  wire logic [2:0]       rd_idx,
    output logic [31:0]           rd_word,
    output logic [5:0]            fill,
    output logic                  busy
);

    logic [511:0] block_reg;
    logic [31:0]  wv_reg [8];
    logic [31:0]  hash_reg [8];
    logic [5:0]   fill_reg;
    logic [5:0]   round_reg;
    logic         run_reg;
    logic         add_reg;

    logic [31:0] w0, w1, w9, w14, sched_new;
    logic [31:0] t1, t2, ch, maj;

    // window of the schedule: word j sits at block_reg[511-32j -: 32]
    assign w0  = block_reg[511:480];
    assign w1  = block_reg[479:448];
    assign w9  = block_reg[223:192];
    assign w14 = block_reg[63:32];

    always_comb begin
        sched_new = shb_pkg::small_sigma1(w14) + w9 + shb_pkg::small_sigma0(w1) + w0;
        ch  = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        maj = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
        t1  = wv_reg[7] + shb_pkg::big_sigma1(wv_reg[4]) + ch
              + shb_pkg::ROUND_K[round_reg] + w0;
        t2  = shb_pkg::big_sigma0(wv_reg[0]) + maj;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            add_reg   <= 1'b0;
            fill_reg  <= '0;
            round_reg <= '0;
            hash_reg  <= shb_pkg::INIT_HASH;
        end else begin
            if (ctl.push) begin
                fill_reg <= fill_reg + 6'd1;
                if (fill_reg == shb_pkg::LAST_FILL) begin
                    run_reg   <= 1'b1;
                    round_reg <= '0;
                end
            end
            if (run_reg) begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == shb_pkg::LAST_ROUND) begin
                    run_reg <= 1'b0;
                    add_reg <= 1'b1;
                end
            end
            if (add_reg) begin
                add_reg <= 1'b0;
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= hash_reg[i] + wv_reg[i];
                end
            end
            if (ctl.init) begin
                hash_reg <= shb_pkg::INIT_HASH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            block_reg <= {block_reg[503:0], ctl.push_byte};
            if (fill_reg == shb_pkg::LAST_FILL) begin
                wv_reg <= hash_reg;
            end
        end else if (run_reg) begin
            block_reg <= {block_reg[479:0], sched_new};
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

    assign rd_word = hash_reg[rd_idx];
    assign fill    = fill_reg;
    assign busy    = run_reg | add_reg;

endmodule

`default_nettype wire
